### design/mqpr_pkg.sv
// shared types and constants of the mqtt packet receiver
`timescale 1ns / 1ps

package mqpr_pkg;

  // recognized packet type bytes
  localparam logic [7:0] TYPE_CONNACK    = 8'h20;
  localparam logic [7:0] TYPE_PUBLISH    = 8'h30;
  localparam logic [7:0] TYPE_PUBLISH_Q1 = 8'h32;
  localparam logic [7:0] TYPE_PUBACK     = 8'h40;
  localparam logic [7:0] TYPE_SUBACK     = 8'h90;

  // result kind codes
  typedef enum logic [2:0] {
    KIND_CONNACK  = 3'd0,
    KIND_PUBACK   = 3'd1,
    KIND_SUBACK   = 3'd2,
    KIND_PUBBYTE  = 3'd3,
    KIND_OVERSIZE = 3'd4
  } kind_t;

  // commands from controller to datapath
  typedef struct packed {
    logic  cap_type;
    logic  cap_len;
    logic  store_byte;
    logic  drop_byte;
    logic  rd_start;
    logic  rd_issue;
    logic  load_ack;
    kind_t ack_kind;
    logic  load_pub;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic  type_known;
    logic  len_zero;
    logic  len_over;
    logic  count_done;
    logic  type_ack;
    kind_t ack_kind;
    logic  type_pub;
    logic  rd_last;
    logic  out_free;
  } dp_sts_t;

endpackage

### design/mqtt_packet_receiver_top.sv
// top level of the mqtt packet receiver
//
// Input channel: one received serial byte per item (in_valid, in_stall, in_rx_byte).
// Bytes are ignored until a known packet type arrives (0x20, 0x30, 0x32, 0x40, 0x90);
// the next byte is the remaining length and that many payload bytes follow.
// Result channel: out_valid, out_stall, packet kind, data byte, byte index, last.
// An ack packet gives one result, registered in the cycle after its final byte is taken.
// A publish of type 0x30 gives type, length and payload bytes from the packet buffer;
// each result is a read issue, held while the result register is full and stalled,
// then a load of the registered buffer read. Input is stalled during a burst.
// A length above PACKET_BYTES-2 is consumed unstored and gives one oversize result,
// a 0x32 packet of legal length gives none. Type bytes are always taken at once; the
// length and payload bytes wait as long as the result register is full and stalled.
// Reset (rst_n low, synchronous) returns to type hunting and empties the result
// register; the buffer holds no valid flags and needs no clearing.
// While out_stall is high the result stays valid and unchanged.
`timescale 1ns / 1ps

module mqtt_packet_receiver_top #(
  parameter int PACKET_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_packet_kind,
  output logic [7:0] out_data_byte,
  output logic [4:0] out_byte_index,
  output logic       out_last
);

  mqpr_pkg::dp_cmd_t cmd;
  mqpr_pkg::dp_sts_t sts;

  // controller
  mqpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  mqpr_dp #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_rx_byte      (in_rx_byte),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_packet_kind (out_packet_kind),
    .out_data_byte   (out_data_byte),
    .out_byte_index  (out_byte_index),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

### design/mqpr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mqpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/mqpr_ctrl.sv
// controller state machine of the mqtt packet receiver
`timescale 1ns / 1ps

module mqpr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mqpr_pkg::dp_sts_t sts,
  output mqpr_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_STORE,
    ST_DROP,
    ST_RD_ISSUE,
    ST_RD_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   finish;
  logic   finish_over;

  // next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    finish         = 1'b0;
    finish_over    = 1'b0;
    cmd.cap_type   = 1'b0;
    cmd.cap_len    = 1'b0;
    cmd.store_byte = 1'b0;
    cmd.drop_byte  = 1'b0;
    cmd.rd_start   = 1'b0;
    cmd.rd_issue   = 1'b0;
    cmd.load_ack   = 1'b0;
    cmd.ack_kind   = mqpr_pkg::KIND_CONNACK;
    cmd.load_pub   = 1'b0;
    unique case (state_r)
      ST_HUNT: begin
        in_stall = 1'b0;
        if (in_valid && sts.type_known) begin
          cmd.cap_type = 1'b1;
          state_nxt    = ST_LEN;
        end
      end
      ST_LEN: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.cap_len = 1'b1;
          priority if (sts.len_zero) begin
            finish = 1'b1;
          end else if (sts.len_over) begin
            state_nxt = ST_DROP;
          end else begin
            state_nxt = ST_STORE;
          end
        end
      end
      ST_STORE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.store_byte = 1'b1;
          finish         = sts.count_done;
        end
      end
      ST_DROP: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.drop_byte = 1'b1;
          finish        = sts.count_done;
          finish_over   = sts.count_done;
        end
      end
      ST_RD_ISSUE: begin
        if (sts.out_free) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_RD_LOAD;
        end
      end
      ST_RD_LOAD: begin
        cmd.load_pub = 1'b1;
        state_nxt    = sts.rd_last ? ST_HUNT : ST_RD_ISSUE;
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase

    // packet completion: ack or oversize result, publish drain or nothing
    if (finish) begin
      priority if (finish_over) begin
        cmd.load_ack = 1'b1;
        cmd.ack_kind = mqpr_pkg::KIND_OVERSIZE;
        state_nxt    = ST_HUNT;
      end else if (sts.type_ack) begin
        cmd.load_ack = 1'b1;
        cmd.ack_kind = sts.ack_kind;
        state_nxt    = ST_HUNT;
      end else if (sts.type_pub) begin
        cmd.rd_start = 1'b1;
        state_nxt    = ST_RD_ISSUE;
      end else begin
        state_nxt = ST_HUNT;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/mqpr_dp.sv
// datapath of the mqtt packet receiver: header registers, buffer, result register
`timescale 1ns / 1ps

module mqpr_dp #(
  parameter int PACKET_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_rx_byte,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [2:0]        out_packet_kind,
  output logic [7:0]        out_data_byte,
  output logic [4:0]        out_byte_index,
  output logic              out_last,
  input  mqpr_pkg::dp_cmd_t cmd,
  output mqpr_pkg::dp_sts_t sts
);

  localparam int AW = $clog2(PACKET_BYTES);
  localparam logic [8:0] MAX_LEN = 9'(PACKET_BYTES - 2);

  logic [7:0]    type_r;
  logic [7:0]    len_r;
  logic [7:0]    cnt_r;
  logic [AW-1:0] rd_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_rdata;

  mqpr_pkg::kind_t kind_r;
  logic [7:0]      data_r;
  logic [4:0]      idx_r;
  logic            last_r;
  logic            valid_r;

  // decode of the incoming byte and of the held header
  always_comb begin
    sts.type_known = (in_rx_byte == mqpr_pkg::TYPE_CONNACK)
                  || (in_rx_byte == mqpr_pkg::TYPE_PUBLISH)
                  || (in_rx_byte == mqpr_pkg::TYPE_PUBLISH_Q1)
                  || (in_rx_byte == mqpr_pkg::TYPE_PUBACK)
                  || (in_rx_byte == mqpr_pkg::TYPE_SUBACK);
    sts.len_zero   = (in_rx_byte == 8'd0);
    sts.len_over   = ({1'b0, in_rx_byte} > MAX_LEN);
    sts.count_done = ((9'(cnt_r) + 9'd1) >= {1'b0, len_r});
    sts.type_pub   = (type_r == mqpr_pkg::TYPE_PUBLISH);
    sts.type_ack   = 1'b1;
    sts.ack_kind   = mqpr_pkg::KIND_CONNACK;
    unique case (type_r)
      mqpr_pkg::TYPE_CONNACK: sts.ack_kind = mqpr_pkg::KIND_CONNACK;
      mqpr_pkg::TYPE_PUBACK:  sts.ack_kind = mqpr_pkg::KIND_PUBACK;
      mqpr_pkg::TYPE_SUBACK:  sts.ack_kind = mqpr_pkg::KIND_SUBACK;
      default:                sts.type_ack = 1'b0;
    endcase
    sts.rd_last    = (9'(rd_r) == (9'(len_r) + 9'd1));
    sts.out_free   = !valid_r || !out_stall;
  end

  // header, byte count and read pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= 8'd0;
      len_r  <= 8'd0;
      cnt_r  <= 8'd0;
      rd_r   <= '0;
    end else begin
      if (cmd.cap_type) begin
        type_r <= in_rx_byte;
      end
      if (cmd.cap_len) begin
        len_r <= in_rx_byte;
        cnt_r <= 8'd0;
      end
      if (cmd.store_byte || cmd.drop_byte) begin
        cnt_r <= cnt_r + 8'd1;
      end
      if (cmd.rd_start) begin
        rd_r <= '0;
      end else if (cmd.load_pub) begin
        rd_r <= rd_r + AW'(1);
      end
    end
  end

  // buffer write address: type, length, then payload
  always_comb begin
    ram_we    = cmd.cap_type || cmd.cap_len || cmd.store_byte;
    priority if (cmd.cap_type) begin
      ram_waddr = AW'(0);
    end else if (cmd.cap_len) begin
      ram_waddr = AW'(1);
    end else begin
      ram_waddr = AW'(9'(cnt_r) + 9'd2);
    end
  end

  mqpr_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_r),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.load_ack || cmd.load_pub) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ack) begin
      kind_r <= cmd.ack_kind;
      data_r <= 8'd0;
      idx_r  <= 5'd0;
      last_r <= 1'b1;
    end else if (cmd.load_pub) begin
      kind_r <= mqpr_pkg::KIND_PUBBYTE;
      data_r <= ram_rdata;
      idx_r  <= 5'(9'(rd_r));
      last_r <= sts.rd_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_packet_kind = kind_r;
  assign out_data_byte   = data_r;
  assign out_byte_index  = idx_r;
  assign out_last        = last_r;

endmodule

### design/mqpr_checker.sv
// port level checks of the mqtt packet receiver and their bind
`timescale 1ns / 1ps

module mqpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_packet_kind,
  input logic [7:0] out_data_byte,
  input logic [4:0] out_byte_index,
  input logic       out_last
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_packet_kind)
      && $stable(out_data_byte) && $stable(out_byte_index) && $stable(out_last))
    else $error("stalled result changed");

  // only publish bytes come in runs, every other kind is a single last item
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_packet_kind != mqpr_pkg::KIND_PUBBYTE) |-> out_last)
    else $error("non publish result without last");

  // non publish results carry zero data and index
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_packet_kind != mqpr_pkg::KIND_PUBBYTE) |-> (out_data_byte == 8'd0)
      && (out_byte_index == 5'd0))
    else $error("non publish result with data");

  // a publish run follows type then length then payload in order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_packet_kind == mqpr_pkg::KIND_PUBBYTE) && !out_last
      ##1 out_valid && (out_packet_kind == mqpr_pkg::KIND_PUBBYTE)
      |-> (out_byte_index == $past(out_byte_index) + 5'd1) || $past(out_valid, 1) == 1'b0)
    else $error("publish byte index out of order");

endmodule

bind mqtt_packet_receiver_top mqpr_checker u_mqpr_checker (.*);
